/* src/tbrl_pkg.sv */
// ----------------------------------------------------------------------------
// tbrl_pkg
// Shared types, codes and reset values for the token bucket rate limiter.
// ----------------------------------------------------------------------------
package tbrl_pkg;

   // Default widths of the byte count and of the token fraction
   localparam int COUNT_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 8;

   // Register reset values (rate: one byte per tick; capacity in bytes)
   localparam logic [63:0] RESET_RATE     = 64'd256;
   localparam logic [63:0] RESET_CAPACITY = 64'd65536;

   // Request kinds
   typedef logic [1:0] kind_type;
   localparam kind_type KIND_TICK    = 2'd0;
   localparam kind_type KIND_ACQUIRE = 2'd1;
   localparam kind_type KIND_REFUND  = 2'd2;
   localparam kind_type KIND_QUERY   = 2'd3;

   // Configuration register indexes
   localparam int CSR_INDEX_WIDTH = 2;
   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;
   localparam csr_index_type CSR_RATE     = 2'd0;
   localparam csr_index_type CSR_CAPACITY = 2'd1;

   // Controller states, one-hot
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EXEC = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic latch_req;    // capture the accepted request
      logic start_div;    // load the divider with deficit and rate
      logic commit_exec;  // update level and load the response
      logic commit_div;   // load the response with the wait quotient
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic needs_div;    // query whose answer needs the divider
      logic div_busy;     // divider still iterating
      logic out_free;     // response register can take a new result
   } status_type;

endpackage

/* src/tbrl_div.sv */
// ----------------------------------------------------------------------------
// tbrl_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tbrl_div #(
   parameter int WIDTH = tbrl_pkg::COUNT_WIDTH_DEF + tbrl_pkg::FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             busy,
   output logic [WIDTH-1:0] quotient,
   output logic             rem_nonzero
);

   localparam int CNT_W = $clog2(WIDTH + 1);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] divisor_ff, divisor_in;
   logic [WIDTH:0]   rem_shift;
   logic [WIDTH:0]   trial;
   logic             fits;

   always_comb begin
      rem_shift  = {rem_ff, quo_ff[WIDTH-1]};
      trial      = rem_shift - {1'b0, divisor_ff};
      fits       = rem_shift >= {1'b0, divisor_ff};
      busy_in    = busy_ff;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         cnt_in     = CNT_W'(WIDTH);
         rem_in     = '0;
         quo_in     = dividend;
         divisor_in = divisor;
      end else if (busy_ff) begin
         // shift in one dividend bit, subtract where the divisor fits
         rem_in  = fits ? trial[WIDTH-1:0] : rem_shift[WIDTH-1:0];
         quo_in  = {quo_ff[WIDTH-2:0], fits};
         cnt_in  = cnt_ff - CNT_W'(1);
         busy_in = cnt_ff != CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign busy        = busy_ff;
   assign quotient    = quo_ff;
   assign rem_nonzero = |rem_ff;

endmodule

/* src/tbrl_ctrl.sv */
// ----------------------------------------------------------------------------
// tbrl_ctrl
// Sequencer: accept a request, execute it, run the divider for a query that needs it.
// ----------------------------------------------------------------------------
module tbrl_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   csr_ready,
   input  tbrl_pkg::status_type   status,
   output tbrl_pkg::cmd_type      cmd
);

   tbrl_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         tbrl_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = tbrl_pkg::ST_EXEC;
            end
         end
         tbrl_pkg::ST_EXEC: begin
            if (status.needs_div) begin
               cmd.start_div = 1'b1;
               state_in      = tbrl_pkg::ST_DIV;
            end else if (status.out_free) begin
               cmd.commit_exec = 1'b1;
               state_in        = tbrl_pkg::ST_IDLE;
            end
         end
         tbrl_pkg::ST_DIV: begin
            if (!status.div_busy) begin
               state_in = tbrl_pkg::ST_DONE;
            end
         end
         tbrl_pkg::ST_DONE: begin
            if (status.out_free) begin
               cmd.commit_div = 1'b1;
               state_in       = tbrl_pkg::ST_IDLE;
            end
         end
         default: state_in = tbrl_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tbrl_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = state_ff == tbrl_pkg::ST_IDLE;
   assign csr_ready = state_ff == tbrl_pkg::ST_IDLE;

endmodule

/* src/tbrl_datapath.sv */
// ----------------------------------------------------------------------------
// tbrl_datapath
// Token level, configuration registers, request decode and response register.
// ----------------------------------------------------------------------------
module tbrl_datapath #(
   parameter int COUNT_WIDTH = tbrl_pkg::COUNT_WIDTH_DEF,
   parameter int FRAC_BITS   = tbrl_pkg::FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  tbrl_pkg::cmd_type               cmd,
   output tbrl_pkg::status_type            status,
   input  tbrl_pkg::kind_type              req_kind,
   input  logic [COUNT_WIDTH-1:0]          req_amount,
   input  logic                            csr_write,
   input  tbrl_pkg::csr_index_type         csr_index,
   input  logic [COUNT_WIDTH+FRAC_BITS-1:0] csr_data,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output logic                            rsp_granted,
   output logic [COUNT_WIDTH-1:0]          rsp_wait_ticks,
   output logic [COUNT_WIDTH-1:0]          rsp_level_bytes
);

   localparam int LW = COUNT_WIDTH + FRAC_BITS;
   localparam logic [COUNT_WIDTH-1:0] CAP_RST_RAW = COUNT_WIDTH'(tbrl_pkg::RESET_CAPACITY);
   localparam logic [COUNT_WIDTH-1:0] CAP_RST =
      (CAP_RST_RAW == '0) ? COUNT_WIDTH'(1) : CAP_RST_RAW;
   localparam logic [LW-1:0] LEVEL_RST = LW'(CAP_RST) << FRAC_BITS;

   tbrl_pkg::kind_type       kind_ff;
   logic [COUNT_WIDTH-1:0]   amount_ff;
   logic [LW-1:0]            rate_ff;
   logic [COUNT_WIDTH-1:0]   cap_ff, cap_in;
   logic [LW-1:0]            level_ff, level_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_granted_ff;
   logic [COUNT_WIDTH-1:0]   rsp_wait_ff;
   logic [COUNT_WIDTH-1:0]   rsp_level_ff;

   logic [COUNT_WIDTH-1:0]   cap_eff;
   logic [LW-1:0]            cap_fx;
   logic [LW-1:0]            nfx;
   logic [LW-1:0]            add_val;
   logic [LW-1:0]            headroom;
   logic [LW-1:0]            level_add;
   logic                     rate_zero, amt_zero, over_cap, covers;
   logic [LW-1:0]            exec_level;
   logic                     exec_grant;
   logic [COUNT_WIDTH-1:0]   exec_wait;
   logic                     needs_div;
   logic [COUNT_WIDTH-1:0]   new_cap_raw, new_cap_eff;
   logic [LW-1:0]            new_cap_fx;
   logic                     div_busy, div_rem_nz;
   logic [LW-1:0]            div_quo;
   logic [LW:0]              quo_ceil;
   logic [COUNT_WIDTH-1:0]   div_wait;

   // Request decode
   always_comb begin
      cap_eff   = (cap_ff == '0) ? COUNT_WIDTH'(1) : cap_ff;
      cap_fx    = LW'(cap_eff) << FRAC_BITS;
      nfx       = LW'(amount_ff) << FRAC_BITS;
      rate_zero = rate_ff == '0;
      amt_zero  = amount_ff == '0;
      over_cap  = amount_ff > cap_eff;
      covers    = level_ff >= nfx;
      add_val   = (kind_ff == tbrl_pkg::KIND_TICK) ? rate_ff : nfx;
      headroom  = cap_fx - level_ff;
      level_add = ((level_ff >= cap_fx) || (add_val >= headroom)) ?
                  cap_fx : level_ff + add_val;
      exec_level = level_ff;
      exec_grant = 1'b0;
      exec_wait  = '0;
      needs_div  = 1'b0;
      unique case (kind_ff)
         tbrl_pkg::KIND_TICK: begin
            if (!rate_zero) exec_level = level_add;
         end
         tbrl_pkg::KIND_ACQUIRE: begin
            if (rate_zero || amt_zero) begin
               exec_grant = 1'b1;
            end else if (!over_cap && covers) begin
               exec_level = level_ff - nfx;
               exec_grant = 1'b1;
            end
         end
         tbrl_pkg::KIND_REFUND: begin
            if (!rate_zero && !amt_zero) exec_level = level_add;
         end
         tbrl_pkg::KIND_QUERY: begin
            if (!rate_zero && !amt_zero) begin
               if (over_cap) begin
                  exec_wait = '1;
               end else if (!covers) begin
                  needs_div = 1'b1;
               end
            end
         end
         default: exec_level = level_ff;
      endcase
   end

   tbrl_div #(
      .WIDTH(LW)
   ) u_div (
      .clock      (clock),
      .reset      (reset),
      .start      (cmd.start_div),
      .dividend   (nfx - level_ff),
      .divisor    (rate_ff),
      .busy       (div_busy),
      .quotient   (div_quo),
      .rem_nonzero(div_rem_nz)
   );

   // Round the quotient up and saturate to the count width
   always_comb begin
      quo_ceil = {1'b0, div_quo} + (LW+1)'(div_rem_nz);
      div_wait = (quo_ceil > (LW+1)'({COUNT_WIDTH{1'b1}})) ? '1 : COUNT_WIDTH'(quo_ceil);
   end

   // Configuration and level update
   always_comb begin
      new_cap_raw = COUNT_WIDTH'(csr_data);
      new_cap_eff = (new_cap_raw == '0) ? COUNT_WIDTH'(1) : new_cap_raw;
      new_cap_fx  = LW'(new_cap_eff) << FRAC_BITS;
      cap_in      = cap_ff;
      level_in    = level_ff;
      if (cmd.commit_exec) begin
         level_in = exec_level;
      end else if (csr_write && csr_index == tbrl_pkg::CSR_CAPACITY) begin
         cap_in = new_cap_raw;
         if (level_ff > new_cap_fx) level_in = new_cap_fx;
      end
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit_exec || cmd.commit_div) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff      <= LW'(tbrl_pkg::RESET_RATE);
         cap_ff       <= CAP_RST_RAW;
         level_ff     <= LEVEL_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write && csr_index == tbrl_pkg::CSR_RATE) rate_ff <= csr_data;
         cap_ff       <= cap_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.latch_req) begin
         kind_ff   <= req_kind;
         amount_ff <= req_amount;
      end
      if (cmd.commit_exec) begin
         rsp_granted_ff <= exec_grant;
         rsp_wait_ff    <= exec_wait;
         rsp_level_ff   <= COUNT_WIDTH'(exec_level >> FRAC_BITS);
      end else if (cmd.commit_div) begin
         rsp_granted_ff <= 1'b0;
         rsp_wait_ff    <= div_wait;
         rsp_level_ff   <= COUNT_WIDTH'(level_ff >> FRAC_BITS);
      end
   end

   assign status.needs_div = needs_div;
   assign status.div_busy  = div_busy;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_granted     = rsp_granted_ff;
   assign rsp_wait_ticks  = rsp_wait_ff;
   assign rsp_level_bytes = rsp_level_ff;

endmodule

/* src/token_bucket_rate_limiter.sv */
// ----------------------------------------------------------------------------
// token_bucket_rate_limiter
// Token bucket with a fixed-point level, tick/acquire/refund/query requests.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one request: kind (tick, try acquire, refund, query wait)
//   and a byte amount. Each request yields exactly one response on rsp_*:
//   granted, wait_ticks (queries only) and the whole-byte level afterwards.
//   csr_* writes rate_per_tick (index 0) or capacity (index 1); write only
//   while no request is in flight. Lowering the capacity clamps the level.
// Sequence:
//   Tick, acquire, refund and a query answered without division have their
//   response registered from the execute state once the response register
//   is free. A query that needs the wait computed runs the restoring
//   divider, one quotient bit per cycle, before its response is registered.
//   One request at a time: the next is taken once this one is committed.
// Reset:
//   Rate returns to one byte per tick, capacity to 65536 bytes, and the
//   bucket starts full. No response is pending.
// Back-pressure:
//   The response sits in an output register; the next request is taken
//   meanwhile and its result holds until rsp_ready frees that register.
// ----------------------------------------------------------------------------
module token_bucket_rate_limiter #(
   parameter int COUNT_WIDTH = tbrl_pkg::COUNT_WIDTH_DEF,
   parameter int FRAC_BITS   = tbrl_pkg::FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_kind,
   input  logic [COUNT_WIDTH-1:0]           req_amount,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_granted,
   output logic [COUNT_WIDTH-1:0]           rsp_wait_ticks,
   output logic [COUNT_WIDTH-1:0]           rsp_level_bytes,
   // configuration channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tbrl_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [COUNT_WIDTH+FRAC_BITS-1:0] csr_data
);

   tbrl_pkg::cmd_type    cmd;
   tbrl_pkg::status_type status;

   // Sequence each request: accept, execute, optionally divide, respond
   tbrl_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .csr_ready(csr_ready),
      .status   (status),
      .cmd      (cmd)
   );

   // Hold the level and registers, decode requests, drive the response
   tbrl_datapath #(
      .COUNT_WIDTH(COUNT_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_kind       (req_kind),
      .req_amount     (req_amount),
      .csr_write      (csr_valid && csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_granted    (rsp_granted),
      .rsp_wait_ticks (rsp_wait_ticks),
      .rsp_level_bytes(rsp_level_bytes)
   );

endmodule

/* verif/tb_token_bucket_rate_limiter.sv */
// ----------------------------------------------------------------------------
// tb_token_bucket_rate_limiter
// Self-checking bench for the token bucket: tick, acquire, refund and query.
// ----------------------------------------------------------------------------
// A directed table walks the bucket through its corners: full and empty,
// unlimited rate, zero and oversized amounts, capacity of zero, lowered
// capacity, saturated waits and a write to an unused register. Random phases
// follow, each with its own rate and capacity and its own mix of request gaps
// and response back-pressure. Every accepted request runs through a local
// copy of the bucket, and each response is compared field by field with the
// oldest outcome still owed.
// ----------------------------------------------------------------------------
module tb_token_bucket_rate_limiter;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW = tbrl_pkg::COUNT_WIDTH_DEF;
   localparam int FB = tbrl_pkg::FRAC_BITS_DEF;
   localparam int LW = CW + FB;

   // No register sits at this index; a write there must change nothing
   localparam tbrl_pkg::csr_index_type CSR_SPARE = 2'd3;

   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 240;
   localparam int DRAIN_CYCLES  = 60;

   typedef struct packed {
      logic          granted;
      logic [CW-1:0] wait_ticks;
      logic [CW-1:0] level_bytes;
   } bucket_outcome_type;

   typedef enum logic {
      ROW_REQUEST,
      ROW_WRITE
   } row_op_type;

   typedef struct packed {
      row_op_type              op;
      tbrl_pkg::kind_type      kind;
      logic [CW-1:0]           amount;
      tbrl_pkg::csr_index_type index;
      logic [LW-1:0]           data;
      logic                    typed;   // outcome below is used instead of the model
      bucket_outcome_type      want;
   } plan_row_type;

   localparam int PLAN_ROWS = 34;

   // Directed walk. Outcomes are typed in where they follow at a glance from
   // the starting state; the rest come from the local bucket copy.
   localparam plan_row_type PLAN [PLAN_ROWS] = '{
      // reset state: rate one byte per tick, capacity 65536, bucket full
      '{ROW_REQUEST, tbrl_pkg::KIND_TICK, 32'd0, tbrl_pkg::CSR_RATE, 40'd0, 1'b1,
        '{1'b0, 32'd0, 32'd65536}},
      '{ROW_REQUEST, tbrl_pkg::KIND_ACQUIRE, 32'd0, tbrl_pkg::CSR_RATE, 40'd0, 1'b1,
        '{1'b1, 32'd0, 32'd65536}},
      '{ROW_REQUEST, tbrl_pkg::KIND_ACQUIRE, 32'd65536, tbrl_pkg::CSR_RATE, 40'd0, 1'b1,
        '{1'b1, 32'd0, 32'd0}},
      '{ROW_REQUEST, tbrl_pkg::KIND_QUERY, 32'd1, tbrl_pkg::CSR_RATE, 40'd0, 1'b1,
        '{1'b0, 32'd1, 32'd0}},
      '{ROW_REQUEST, tbrl_pkg::KIND_QUERY, 32'd65537, tbrl_pkg::CSR_RATE, 40'd0, 1'b1,
        '{1'b0, 32'hFFFF_FFFF, 32'd0}},
      '{ROW_REQUEST, tbrl_pkg::KIND_ACQUIRE, 32'hFFFF_FFFF, tbrl_pkg::CSR_RATE,
        40'd0, 1'b1, '{1'b0, 32'd0, 32'd0}},
      '{ROW_REQUEST, tbrl_pkg::KIND_TICK, 32'hFFFF_FFFF, tbrl_pkg::CSR_RATE,
        40'd0, 1'b1, '{1'b0, 32'd0, 32'd1}},
      '{ROW_REQUEST, tbrl_pkg::KIND_REFUND, 32'hFFFF_FFFF, tbrl_pkg::CSR_RATE,
        40'd0, 1'b1, '{1'b0, 32'd0, 32'd65536}},
      '{ROW_REQUEST, tbrl_pkg::KIND_REFUND, 32'd0, tbrl_pkg::CSR_RATE, 40'd0, 1'b1,
        '{1'b0, 32'd0, 32'd65536}},
      '{ROW_REQUEST, tbrl_pkg::KIND_ACQUIRE, 32'd1, tbrl_pkg::CSR_RATE, 40'd0, 1'b1,
        '{1'b1, 32'd0, 32'd65535}},
      '{ROW_REQUEST, tbrl_pkg::KIND_QUERY, 32'd65536, tbrl_pkg::CSR_RATE, 40'd0, 1'b1,
        '{1'b0, 32'd1, 32'd65535}},
      '{ROW_REQUEST, tbrl_pkg::KIND_QUERY, 32'd0, tbrl_pkg::CSR_RATE, 40'd0, 1'b1,
        '{1'b0, 32'd0, 32'd65535}},
      // unlimited rate: everything granted, nothing moves
      '{ROW_WRITE, tbrl_pkg::KIND_TICK, 32'd0, tbrl_pkg::CSR_RATE, 40'd0, 1'b0, '0},
      '{ROW_REQUEST, tbrl_pkg::KIND_ACQUIRE, 32'hFFFF_FFFF, tbrl_pkg::CSR_RATE,
        40'd0, 1'b1, '{1'b1, 32'd0, 32'd65535}},
      '{ROW_REQUEST, tbrl_pkg::KIND_TICK, 32'd0, tbrl_pkg::CSR_RATE, 40'd0, 1'b1,
        '{1'b0, 32'd0, 32'd65535}},
      '{ROW_REQUEST, tbrl_pkg::KIND_REFUND, 32'd5, tbrl_pkg::CSR_RATE, 40'd0, 1'b1,
        '{1'b0, 32'd0, 32'd65535}},
      '{ROW_REQUEST, tbrl_pkg::KIND_QUERY, 32'hFFFF_FFFF, tbrl_pkg::CSR_RATE,
        40'd0, 1'b1, '{1'b0, 32'd0, 32'd65535}},
      // slowest rate: 1/256 byte per tick, drain then ask for a full bucket
      '{ROW_WRITE, tbrl_pkg::KIND_TICK, 32'd0, tbrl_pkg::CSR_RATE, 40'd1, 1'b0, '0},
      '{ROW_REQUEST, tbrl_pkg::KIND_ACQUIRE, 32'd65535, tbrl_pkg::CSR_RATE, 40'd0, 1'b1,
        '{1'b1, 32'd0, 32'd0}},
      '{ROW_REQUEST, tbrl_pkg::KIND_QUERY, 32'd65536, tbrl_pkg::CSR_RATE, 40'd0, 1'b1,
        '{1'b0, 32'h0100_0000, 32'd0}},
      // zero capacity behaves as one byte
      '{ROW_WRITE, tbrl_pkg::KIND_TICK, 32'd0, tbrl_pkg::CSR_CAPACITY, 40'd0, 1'b0, '0},
      '{ROW_REQUEST, tbrl_pkg::KIND_QUERY, 32'd2, tbrl_pkg::CSR_RATE, 40'd0, 1'b1,
        '{1'b0, 32'hFFFF_FFFF, 32'd0}},
      '{ROW_REQUEST, tbrl_pkg::KIND_TICK, 32'd0, tbrl_pkg::CSR_RATE, 40'd0, 1'b0, '0},
      // largest rate saturates on one tick
      '{ROW_WRITE, tbrl_pkg::KIND_TICK, 32'd0, tbrl_pkg::CSR_RATE,
        40'hFF_FFFF_FFFF, 1'b0, '0},
      '{ROW_REQUEST, tbrl_pkg::KIND_TICK, 32'd0, tbrl_pkg::CSR_RATE, 40'd0, 1'b1,
        '{1'b0, 32'd0, 32'd1}},
      // largest capacity with slowest rate: wait quotient overflows
      '{ROW_WRITE, tbrl_pkg::KIND_TICK, 32'd0, tbrl_pkg::CSR_CAPACITY,
        40'hFF_FFFF_FFFF, 1'b0, '0},
      '{ROW_WRITE, tbrl_pkg::KIND_TICK, 32'd0, tbrl_pkg::CSR_RATE, 40'd1, 1'b0, '0},
      '{ROW_REQUEST, tbrl_pkg::KIND_ACQUIRE, 32'd1, tbrl_pkg::CSR_RATE, 40'd0, 1'b1,
        '{1'b1, 32'd0, 32'd0}},
      '{ROW_REQUEST, tbrl_pkg::KIND_QUERY, 32'hFFFF_FFFF, tbrl_pkg::CSR_RATE,
        40'd0, 1'b1, '{1'b0, 32'hFFFF_FFFF, 32'd0}},
      '{ROW_REQUEST, tbrl_pkg::KIND_REFUND, 32'hFFFF_FFFF, tbrl_pkg::CSR_RATE,
        40'd0, 1'b1, '{1'b0, 32'd0, 32'hFFFF_FFFF}},
      // lowering the capacity clamps the level right away
      '{ROW_WRITE, tbrl_pkg::KIND_TICK, 32'd0, tbrl_pkg::CSR_CAPACITY,
        40'd100, 1'b0, '0},
      '{ROW_REQUEST, tbrl_pkg::KIND_TICK, 32'd0, tbrl_pkg::CSR_RATE, 40'd0, 1'b1,
        '{1'b0, 32'd0, 32'd100}},
      // write to the unused index; capacity must still read as 100
      '{ROW_WRITE, tbrl_pkg::KIND_TICK, 32'd0, CSR_SPARE, 40'd0, 1'b0, '0},
      '{ROW_REQUEST, tbrl_pkg::KIND_ACQUIRE, 32'd100, tbrl_pkg::CSR_RATE, 40'd0, 1'b1,
        '{1'b1, 32'd0, 32'd0}}
   };

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic [1:0]              req_kind;
   logic [CW-1:0]           req_amount;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic                    rsp_granted;
   logic [CW-1:0]           rsp_wait_ticks;
   logic [CW-1:0]           rsp_level_bytes;
   logic                    csr_valid;
   logic                    csr_ready;
   tbrl_pkg::csr_index_type csr_index;
   logic [LW-1:0]           csr_data;

   // Local copy of the bucket and its registers
   logic [LW-1:0]       rate_reg;
   logic [CW-1:0]       cap_reg;
   logic [63:0]         level_fx;

   bucket_outcome_type  bucket_outcomes [$];

   int unsigned         send_idle_pct;
   int unsigned         stall_pct;
   int unsigned         mismatches;
   int unsigned         accepted_count;
   int unsigned         write_count;
   int unsigned         grant_count;
   int unsigned         deny_count;
   int unsigned         never_count;
   int unsigned         divide_count;

   token_bucket_rate_limiter dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_amount      (req_amount),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_granted     (rsp_granted),
      .rsp_wait_ticks  (rsp_wait_ticks),
      .rsp_level_bytes (rsp_level_bytes),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop well past the slowest legal run
   initial begin
      #5_000_000;
      $display("token_bucket_rate_limiter test failed");
      $finish;
   end

   // ------------------------------------------------------------------
   // Bucket arithmetic
   // ------------------------------------------------------------------
   function automatic logic [63:0] whole_capacity();
      return (cap_reg == '0) ? 64'd1 : {{(64-CW){1'b0}}, cap_reg};
   endfunction

   // Add to the level, clamp at the (fixed-point) capacity
   function automatic void fill_bucket(logic [63:0] tokens);
      logic [63:0] ceiling;
      ceiling = whole_capacity() << FB;
      if (level_fx >= ceiling || tokens >= ceiling - level_fx)
         level_fx = ceiling;
      else
         level_fx = level_fx + tokens;
   endfunction

   function automatic void load_register(tbrl_pkg::csr_index_type idx,
                                         logic [LW-1:0] value);
      if (idx == tbrl_pkg::CSR_RATE) begin
         rate_reg = value;
      end else if (idx == tbrl_pkg::CSR_CAPACITY) begin
         cap_reg = value[CW-1:0];
         if (level_fx > (whole_capacity() << FB))
            level_fx = whole_capacity() << FB;
      end
   endfunction

   // Run one request through the bucket and return what it reports
   function automatic bucket_outcome_type apply_to_bucket(tbrl_pkg::kind_type kind,
                                                          logic [CW-1:0] amount);
      logic [63:0]        need;
      logic [63:0]        rate64;
      logic [63:0]        deficit;
      logic [63:0]        quotient;
      bucket_outcome_type res;
      res    = '0;
      need   = {{(64-CW){1'b0}}, amount} << FB;
      rate64 = {{(64-LW){1'b0}}, rate_reg};
      unique case (kind)
         tbrl_pkg::KIND_TICK: begin
            if (rate64 != 0) fill_bucket(rate64);
         end
         tbrl_pkg::KIND_ACQUIRE: begin
            if (rate64 == 0 || amount == '0) begin
               res.granted = 1'b1;
            end else if ({32'd0, amount} <= whole_capacity() && level_fx >= need) begin
               level_fx    = level_fx - need;
               res.granted = 1'b1;
            end
         end
         tbrl_pkg::KIND_REFUND: begin
            if (rate64 != 0 && amount != '0) fill_bucket(need);
         end
         tbrl_pkg::KIND_QUERY: begin
            if (rate64 == 0 || amount == '0) begin
               res.wait_ticks = '0;
            end else if ({32'd0, amount} > whole_capacity()) begin
               res.wait_ticks = '1;
            end else if (level_fx < need) begin
               deficit  = need - level_fx;
               quotient = deficit / rate64;
               if (deficit % rate64 != 0) quotient = quotient + 1;
               res.wait_ticks = (quotient > {{(64-CW){1'b0}}, {CW{1'b1}}}) ?
                                '1 : quotient[CW-1:0];
            end
         end
      endcase
      res.level_bytes = level_fx[FB +: CW];
      return res;
   endfunction

   // ------------------------------------------------------------------
   // Drivers: every task starts and ends at a falling edge
   // ------------------------------------------------------------------
   task automatic issue_request(tbrl_pkg::kind_type kind, logic [CW-1:0] amount,
                                logic typed, bucket_outcome_type want);
      bucket_outcome_type model;
      // idle the request channel for a random stretch
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid  = 1'b1;
      req_kind   = kind;
      req_amount = amount;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      model = apply_to_bucket(kind, amount);
      bucket_outcomes.push_back(typed ? want : model);
      accepted_count++;
      if (kind == tbrl_pkg::KIND_ACQUIRE) begin
         if (model.granted) grant_count++;
         else deny_count++;
      end
      if (kind == tbrl_pkg::KIND_QUERY) begin
         if (model.wait_ticks == '1) never_count++;
         else if (model.wait_ticks != '0) divide_count++;
      end
      @(negedge clock);
   endtask

   task automatic write_register(tbrl_pkg::csr_index_type idx, logic [LW-1:0] value);
      // drop the request channel and let every owed response drain first
      req_valid = 1'b0;
      while (bucket_outcomes.size() != 0) @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      load_register(idx, value);
      write_count++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Bias amounts toward the capacity so the bucket actually empties and fills
   function automatic logic [CW-1:0] pick_amount();
      logic [CW-1:0] cap;
      int unsigned   roll;
      cap  = CW'(whole_capacity());
      roll = $urandom_range(99);
      if (roll < 8)       return '0;
      else if (roll < 16) return $urandom;
      else if (roll < 24) return cap + $urandom_range(0, 1);
      else if (roll < 50) return $urandom_range(1, cap);
      else                return $urandom_range(1, cap / 16 + 1);
   endfunction

   function automatic tbrl_pkg::kind_type pick_kind();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 30)      return tbrl_pkg::KIND_TICK;
      else if (roll < 60) return tbrl_pkg::KIND_ACQUIRE;
      else if (roll < 75) return tbrl_pkg::KIND_REFUND;
      else                return tbrl_pkg::KIND_QUERY;
   endfunction

   // ------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------
   task automatic note_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
      mismatches++;
   endtask

   // Stall the receiver at random; hold ready low through reset
   always @(negedge clock) begin
      rsp_ready = reset ? 1'b0 : ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      bucket_outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (bucket_outcomes.size() == 0) begin
            note_mismatch("response with no request owed", 64'(rsp_level_bytes), 64'd0);
         end else begin
            want = bucket_outcomes.pop_front();
            if (rsp_granted !== want.granted)
               note_mismatch("granted", 64'(rsp_granted), 64'(want.granted));
            if (rsp_wait_ticks !== want.wait_ticks)
               note_mismatch("wait_ticks", 64'(rsp_wait_ticks), 64'(want.wait_ticks));
            if (rsp_level_bytes !== want.level_bytes)
               note_mismatch("level_bytes", 64'(rsp_level_bytes), 64'(want.level_bytes));
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin
      logic [LW-1:0] rate_pick;
      logic [LW-1:0] cap_pick;
      req_valid      = 1'b0;
      req_kind       = tbrl_pkg::KIND_TICK;
      req_amount     = '0;
      csr_valid      = 1'b0;
      csr_index      = tbrl_pkg::CSR_RATE;
      csr_data       = '0;
      send_idle_pct  = 0;
      stall_pct      = 0;
      mismatches     = 0;
      accepted_count = 0;
      write_count    = 0;
      grant_count    = 0;
      deny_count     = 0;
      never_count    = 0;
      divide_count   = 0;

      // bucket starts full at the reset capacity
      rate_reg = tbrl_pkg::RESET_RATE[LW-1:0];
      cap_reg  = tbrl_pkg::RESET_CAPACITY[CW-1:0];
      level_fx = whole_capacity() << FB;

      reset = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed walk, back to back
      for (int r = 0; r < PLAN_ROWS; r++) begin
         if (PLAN[r].op == ROW_WRITE)
            write_register(PLAN[r].index, PLAN[r].data);
         else
            issue_request(PLAN[r].kind, PLAN[r].amount, PLAN[r].typed, PLAN[r].want);
      end

      // random phases: new registers each time, idling pattern rotates
      for (int p = 0; p < PHASES; p++) begin
         unique case (p)
            0: begin
               rate_pick = tbrl_pkg::RESET_RATE[LW-1:0];
               cap_pick  = tbrl_pkg::RESET_CAPACITY[LW-1:0];
            end
            1: begin
               rate_pick = LW'($urandom_range(1, 4096));
               cap_pick  = LW'($urandom_range(1, 5000));
            end
            2: begin
               rate_pick = '0;
               cap_pick  = LW'($urandom_range(1, 1000));
            end
            3: begin
               rate_pick = '1;
               cap_pick  = '1;
            end
            4: begin
               rate_pick = 40'd1;
               cap_pick  = 40'd1;
            end
            5: begin
               rate_pick = {8'($urandom_range(0, 255)), $urandom};
               cap_pick  = {8'($urandom_range(0, 255)), $urandom};
            end
            6: begin
               rate_pick = LW'($urandom_range(1, 65535));
               cap_pick  = {8'($urandom_range(0, 255)), 32'd0};
            end
            default: begin
               rate_pick = LW'($urandom_range(256, 1 << 20));
               cap_pick  = LW'($urandom_range(1000, 100000));
            end
         endcase
         unique case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 66; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 66; end
            default: begin send_idle_pct = 11; stall_pct = 11; end
         endcase
         write_register(tbrl_pkg::CSR_RATE, rate_pick);
         write_register(tbrl_pkg::CSR_CAPACITY, cap_pick);
         // random data into the unused index must leave both registers alone
         if (p == 5) write_register(CSR_SPARE, {8'($urandom_range(0, 255)), $urandom});
         for (int i = 0; i < PHASE_ITEMS; i++)
            issue_request(pick_kind(), pick_amount(), 1'b0, '0);
      end

      // drain: release the channel, wait for every owed response, then settle
      req_valid = 1'b0;
      while (bucket_outcomes.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d requests under %0d register writes, %0d phases of idling",
               accepted_count, write_count, PHASES);
      $display("acquires granted %0d / denied %0d; queries dividing %0d / never %0d",
               grant_count, deny_count, divide_count, never_count);
      if (mismatches == 0) begin
         $display("token_bucket_rate_limiter test passed");
      end else begin
         $display("token_bucket_rate_limiter test failed");
      end
      $finish;
   end

endmodule
